FILE: sv/rndis_pkg.sv
package rndis_pkg;

  localparam int HEADER_BYTES    = 44;
  localparam int HDR_WORD_BYTES  = 16;
  localparam int OFFSET_BASE     = 8;
  localparam int MIN_DATA_OFFSET = HEADER_BYTES - OFFSET_BASE;
  localparam int MIN_FRAME_BYTES = 14;
  localparam logic [31:0] PACKET_TYPE = 32'd1;

  localparam int CNT_W = 11;

  localparam logic [1:0] MODE_HDR  = 2'd0;
  localparam logic [1:0] MODE_PAY  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload_byte;
    logic             frame_first;
    logic             frame_last;
    logic             status;
    logic [CNT_W-1:0] frames_delivered;
  } rndis_res_t;

  // results produced by one byte: optional payload word, then optional status
  typedef struct packed {
    logic       pay_v;
    logic       stat_v;
    rndis_res_t pay;
    rndis_res_t stat;
  } rndis_step_t;

endpackage

FILE: sv/rndis_packet_deframer.sv
// channel  dir  tdata                                      tuser                  tlast
// in_      in   [7:0] data_byte, [24:8] buffer_len         buffer_start           -
// out_     out  [7:0] payload_byte, [8] status,            [0] kind,              frame_last
//               [19:9] frames_delivered                    [1] frame_first
//
// One byte per cycle sustained while the output takes each word and no status is queued;
// a byte passes from the input register through the parser into the output register.
// The last byte of a transfer that also carries a payload byte yields two words; the
// input register then holds the next byte while the status drains.
// Reset (rst_n low, synchronous) clears parser state; no transfer is open afterwards.
// Output stall: one byte still enters the input register while a result waits.
module rndis_packet_deframer
  import rndis_pkg::*;
#(
  parameter int MAX_TRANSFER_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // data_byte, buffer_len, zero pad
  input  logic        in_tuser,   // buffer_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // payload_byte, status, frames_delivered, zero pad
  output logic [1:0]  out_tuser,  // kind, frame_first
  output logic        out_tlast   // frame_last
);

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_start_r;
  logic [16:0] in_len_r;
  logic        adv;
  logic        can_take;
  logic        pend_v;
  rndis_step_t step_res;
  rndis_res_t  out_res;

  assign adv       = in_v_r && can_take;
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata[7:0];
      in_len_r   <= in_tdata[24:8];
      in_start_r <= in_tuser;
    end
  end

  rndis_parse #(
    .MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .data_byte   (in_byte_r),
    .buffer_start(in_start_r),
    .buffer_len  (in_len_r),
    .res         (step_res)
  );

  rndis_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (adv),
    .res      (step_res),
    .can_take (can_take),
    .pend_v   (pend_v),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = {4'd0, out_res.frames_delivered, out_res.status, out_res.payload_byte};
  assign out_tuser = {out_res.frame_first, out_res.kind};
  assign out_tlast = out_res.frame_last;

  // a byte held in the input register is never dropped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r)
    else $error("input byte lost while stalled");

  // a queued status word always sits behind a visible word
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v |-> out_tvalid)
    else $error("pending status without output word");

  // a byte producing two words queues the status
  a_two: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step_res.pay_v && step_res.stat_v |=> out_tvalid && pend_v)
    else $error("second result of a byte not queued");

endmodule

FILE: sv/rndis_parse.sv
module rndis_parse
  import rndis_pkg::*;
#(
  parameter int MAX_TRANSFER_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        buffer_start,
  input  logic [16:0] buffer_len,
  output rndis_step_t res
);

  localparam int LEN_W = $clog2(MAX_TRANSFER_BYTES + 1);

  logic [LEN_W-1:0] rem_r, rem_nxt;    // bytes left in transfer, incl. current
  logic [LEN_W-1:0] rel_r, rel_nxt;    // offset inside current message
  logic [LEN_W-1:0] room_r, room_nxt;  // transfer bytes from message start
  logic [1:0]       mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             err_r, err_nxt;
  logic [31:0]      hw_r [4];
  logic [31:0]      hw_nxt [4];
  logic [32:0]      hend_r, hend_nxt;
  logic [33:0]      dend_r, dend_nxt;

  logic [LEN_W-1:0] len_c;
  logic [31:0]      len_ext;
  logic [LEN_W-1:0] rem_e, rel_e, room_e;
  logic [1:0]       mode_e, mode_c;
  logic [CNT_W-1:0] cnt_e, cnt_c;
  logic             err_e, err_c;
  logic             active;
  logic [33:0]      rel34;
  logic [LEN_W-1:0] rem_dec;

  always_comb begin
    len_ext = 32'(buffer_len);
    if (len_ext == 32'd0) begin
      len_ext = 32'd1;
    end
    if (len_ext > 32'(MAX_TRANSFER_BYTES)) begin
      len_ext = 32'(MAX_TRANSFER_BYTES);
    end
    len_c = LEN_W'(len_ext);
  end

  always_comb begin
    if (buffer_start) begin
      rem_e  = len_c;
      rel_e  = '0;
      room_e = len_c;
      mode_e = (32'(len_c) >= 32'(HEADER_BYTES)) ? MODE_HDR : MODE_STOP;
      cnt_e  = '0;
      err_e  = 1'b0;
    end else begin
      rem_e  = rem_r;
      rel_e  = rel_r;
      room_e = room_r;
      mode_e = mode_r;
      cnt_e  = cnt_r;
      err_e  = err_r;
    end
  end

  assign active  = (rem_e != '0);
  assign rel34   = 34'(rel_e);
  assign rem_dec = rem_e - LEN_W'(1);

  always_comb begin
    mode_c   = mode_e;
    cnt_c    = cnt_e;
    err_c    = err_e;
    hw_nxt   = hw_r;
    hend_nxt = hend_r;
    dend_nxt = dend_r;
    rem_nxt  = rem_e;
    rel_nxt  = rel_e;
    room_nxt = room_e;
    mode_nxt = mode_e;
    res      = '0;
    res.pay.kind  = KIND_PAYLOAD;
    res.stat.kind = KIND_STATUS;

    if (active) begin
      case (mode_e)
        MODE_HDR: begin
          if (32'(rel_e) < 32'(HDR_WORD_BYTES)) begin
            hw_nxt[rel_e[3:2]][8*rel_e[1:0] +: 8] = data_byte;
          end
          // offsets settle well before the last header byte
          hend_nxt = 33'(OFFSET_BASE) + 33'(hw_r[2]);
          dend_nxt = 34'(hend_r) + 34'(hw_r[3]);
          if (32'(rel_e) == 32'(HEADER_BYTES - 1)) begin
            if (hw_r[0] != PACKET_TYPE) begin
              mode_c = MODE_STOP;
            end else if (hw_r[1] < 32'(HEADER_BYTES)) begin
              err_c  = 1'b1;
              mode_c = MODE_STOP;
            end else if (hw_r[1] > 32'(room_e)) begin
              mode_c = MODE_STOP;
            end else if (hw_r[2] < 32'(MIN_DATA_OFFSET) ||
                         hw_r[3] < 32'(MIN_FRAME_BYTES) ||
                         dend_r > 34'(hw_r[1])) begin
              err_c  = 1'b1;
              mode_c = MODE_STOP;
            end else begin
              if (cnt_e != '1) begin
                cnt_c = cnt_e + CNT_W'(1);
              end
              mode_c = MODE_PAY;
            end
          end
        end
        MODE_PAY: begin
          if (rel34 >= 34'(hend_r) && rel34 < dend_r) begin
            res.pay_v            = 1'b1;
            res.pay.payload_byte = data_byte;
            res.pay.frame_first  = (rel34 == 34'(hend_r));
            res.pay.frame_last   = (rel34 + 34'd1 == dend_r);
          end
        end
        default: ;
      endcase

      mode_nxt = mode_c;
      rel_nxt  = rel_e + LEN_W'(1);
      if (mode_c == MODE_PAY && (33'(rel_e) + 33'd1 == 33'(hw_r[1]))) begin
        rel_nxt  = '0;
        room_nxt = rem_dec;
        mode_nxt = (32'(rem_dec) >= 32'(HEADER_BYTES)) ? MODE_HDR : MODE_STOP;
      end

      if (rem_e == LEN_W'(1)) begin
        res.stat_v                = 1'b1;
        res.stat.status           = err_c;
        res.stat.frames_delivered = cnt_c;
      end
      rem_nxt = rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      rel_r  <= '0;
      room_r <= '0;
      mode_r <= MODE_HDR;
      cnt_r  <= '0;
      err_r  <= 1'b0;
    end else if (step) begin
      rem_r  <= rem_nxt;
      rel_r  <= rel_nxt;
      room_r <= room_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_c;
      err_r  <= err_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r   <= '{default: '0};
      hend_r <= '0;
      dend_r <= '0;
    end else if (step) begin
      hw_r   <= hw_nxt;
      hend_r <= hend_nxt;
      dend_r <= dend_nxt;
    end
  end

endmodule

FILE: sv/rndis_outq.sv
module rndis_outq
  import rndis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rndis_step_t res,
  output logic        can_take,
  output logic        pend_v,
  output logic        out_valid,
  input  logic        out_ready,
  output rndis_res_t  out_res
);

  logic       out_v_r, pend_v_r;
  rndis_res_t out_r, pend_r;
  logic       has_res;

  assign can_take  = !pend_v_r && (!out_v_r || out_ready);
  assign has_res   = res.pay_v || res.stat_v;
  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign pend_v    = pend_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else if (push && has_res) begin
      out_v_r  <= 1'b1;
      pend_v_r <= res.pay_v && res.stat_v;
    end else if (out_v_r && out_ready) begin
      out_v_r  <= pend_v_r;
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && has_res) begin
      out_r  <= res.pay_v ? res.pay : res.stat;
      pend_r <= res.stat;
    end else if (out_v_r && out_ready) begin
      out_r  <= pend_r;
    end
  end

endmodule
